// File: hdl/umf_pkg.sv
// Package with shared constants and types for the minifloat arithmetic unit.
`default_nettype none
package umf_pkg;
    localparam int EXP_BITS_DEF = 8;
    localparam int MAN_BITS_DEF = 23;
    localparam int D_MAN = 52;
    localparam int D_EXP = 11;
    localparam int D_BIAS = 1023;
    localparam logic [63:0] D_INF = 64'h7ff0000000000000;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_MUL = 2'd1,
        FN_FROM_D = 2'd2,
        FN_TO_D = 2'd3
    } func_t;
endpackage
`default_nettype wire

// File: hdl/umf_mul.sv
// Pipelined mantissa product (mx*my) >> MAN_BITS, split into 26x26-bit partial products.
`default_nettype none
module umf_mul import umf_pkg::*;
#(
    parameter int MAN_BITS = MAN_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [MAN_BITS-1:0] x,
    input  wire logic [MAN_BITS-1:0] y,
    output logic      [MAN_BITS:0]   prod
);
    localparam int H = 26;
    logic [51:0] xw, yw;
    logic [51:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [104:0] full;

    assign xw = 52'(x);
    assign yw = 52'(y);

    // Stage one: four 26x26 partial products, each in a register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= xw[H-1:0] * yw[H-1:0];
            lh_reg <= xw[H-1:0] * yw[51:H];
            hl_reg <= xw[51:H] * yw[H-1:0];
            hh_reg <= xw[51:H] * yw[51:H];
        end
    end

    assign full = 105'(ll_reg) + (105'(lh_reg) << H) + (105'(hl_reg) << H)
                + (105'(hh_reg) << (2 * H));
    // The product stays below 2^(2M), so the shifted value fits M+1 bits.
    assign prod = (MAN_BITS + 1)'(full >> MAN_BITS);
endmodule
`default_nettype wire

// File: hdl/umf_front.sv
// First stage logic: operand decode, add alignment, multiply exponent and mantissa sums, and conversions.
`default_nettype none
module umf_front import umf_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MAN_BITS = MAN_BITS_DEF
)
(
    input  wire logic [1:0]                   func,
    input  wire logic [63:0]                  operand_a,
    input  wire logic [63:0]                  operand_b,
    output logic      [EXP_BITS+1:0]          exp_s,
    output logic      [MAN_BITS+1:0]          man_s,
    output logic      [63:0]                  direct,
    output logic                              is_direct
);
    localparam int W = EXP_BITS + MAN_BITS;
    localparam int BIAS = (1 << (EXP_BITS - 1)) - 1;
    logic [W-1:0] x, y;
    logic [EXP_BITS-1:0] ex, ey, eb, es;
    logic [MAN_BITS-1:0] mx, my, mb, ms;
    logic [EXP_BITS-1:0] d;
    logic [MAN_BITS:0] hid;
    logic [12:0] fe;
    logic [62:0] dbits;
    logic [D_EXP-1:0] te;

    always_comb
    begin
        x = operand_a[W-1:0];
        y = operand_b[W-1:0];
        ex = x[W-1:MAN_BITS];
        ey = y[W-1:MAN_BITS];
        mx = x[MAN_BITS-1:0];
        my = y[MAN_BITS-1:0];
        if (ex >= ey)
        begin
            eb = ex; mb = mx; es = ey; ms = my;
        end
        else
        begin
            eb = ey; mb = my; es = ex; ms = mx;
        end
        d = eb - es;
        hid = {1'b1, ms};
        exp_s = '0;
        man_s = '0;
        direct = '0;
        is_direct = 1'b0;
        dbits = operand_a[62:0];
        fe = 13'(dbits[62:D_MAN]) - 13'(D_BIAS) + 13'(BIAS);
        te = D_EXP'(ex) + D_EXP'(D_BIAS - BIAS);
        case (func)
            FN_ADD:
            begin
                if (x == '0)
                begin
                    is_direct = 1'b1; direct = 64'(y);
                end
                else if (y == '0)
                begin
                    is_direct = 1'b1; direct = 64'(x);
                end
                else
                begin
                    exp_s = (EXP_BITS + 2)'(eb);
                    man_s = (MAN_BITS + 2)'(mb);
                    if (32'(d) <= MAN_BITS)
                        man_s = man_s + (MAN_BITS + 2)'(hid >> d);
                end
            end
            FN_MUL:
            begin
                if (x == '0 || y == '0)
                begin
                    is_direct = 1'b1; direct = '0;
                end
                else
                begin
                    exp_s = (EXP_BITS + 2)'(ex) + (EXP_BITS + 2)'(ey)
                          - (EXP_BITS + 2)'(BIAS);
                    man_s = (MAN_BITS + 2)'(mx) + (MAN_BITS + 2)'(my);
                end
            end
            FN_FROM_D:
            begin
                is_direct = 1'b1;
                if (dbits == '0)
                    direct = '0;
                else if (fe[12])
                    direct = '0;
                else if (fe > 13'(2 * BIAS))
                    direct = 64'({{EXP_BITS{1'b1}}, {MAN_BITS{1'b0}}});
                else
                    direct = 64'({fe[EXP_BITS-1:0],
                                  dbits[D_MAN-1 -: MAN_BITS]});
            end
            default:
            begin
                is_direct = 1'b1;
                if (x == '0)
                    direct = '0;
                else if (x == {{EXP_BITS{1'b1}}, {MAN_BITS{1'b0}}})
                    direct = D_INF;
                else
                    direct = {1'b0, te, mx, {(D_MAN - MAN_BITS){1'b0}}};
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/unsigned_minifloat_add_mul_convert_top.sv
// Top level of the pipelined unsigned minifloat add, multiply and convert unit.
//
// One input channel (func, operand_a, operand_b with valid/stall) and one
// output channel (result with valid/stall). A transfer happens at a rising
// edge where valid is high and stall is low.
// Pipeline: stage 1 decodes, aligns the add operands, adds mantissas for
// multiply and finishes conversions, while the mantissa multiplier registers
// its four partial products beside it; stage 2 holds the summed mantissa
// with the product term folded in; stage 3 holds the packed result
// after renormalization and overflow/underflow checks. Throughput is one
// transfer per cycle while the output is not stalled; the multiplier's
// partial product register sets the stage split.
// The whole pipeline advances only when the output stage is empty or its
// result is taken, so a stall at the output holds every stage and neither
// loses nor repeats an item; input stall is driven by that same condition.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module unsigned_minifloat_add_mul_convert_top import umf_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MAN_BITS = MAN_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result
);
    localparam int W = EXP_BITS + MAN_BITS;
    localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

    logic adv;
    logic [EXP_BITS+1:0] exp_s;
    logic [MAN_BITS+1:0] man_s;
    logic [63:0] direct;
    logic is_direct;
    logic [MAN_BITS:0] prod;

    logic v1_reg, v2_reg, v3_reg;
    logic [EXP_BITS+1:0] e1_reg, e2_reg;
    logic [MAN_BITS+1:0] m1_reg, m2_reg;
    logic [63:0] d1_reg, d2_reg, r3_reg;
    logic dir1_reg, dir2_reg, mul1_reg;
    logic [63:0] r3_next;
    logic [MAN_BITS+1:0] msum;
    logic [EXP_BITS+1:0] efin;
    logic [MAN_BITS-1:0] mfin;

    assign adv = !v3_reg || !out_stall;
    assign in_stall = !adv;
    assign out_valid = v3_reg;
    assign result = r3_reg;

    umf_front #(.EXP_BITS(EXP_BITS), .MAN_BITS(MAN_BITS)) u_front
    (
        .func(func), .operand_a(operand_a), .operand_b(operand_b),
        .exp_s(exp_s), .man_s(man_s), .direct(direct), .is_direct(is_direct)
    );

    umf_mul #(.MAN_BITS(MAN_BITS)) u_mul
    (
        .clk(clk), .en(adv),
        .x(operand_a[MAN_BITS-1:0]), .y(operand_b[MAN_BITS-1:0]),
        .prod(prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= exp_s;
            m1_reg <= man_s;
            d1_reg <= direct;
            dir1_reg <= is_direct;
            mul1_reg <= (func == FN_MUL);
            e2_reg <= e1_reg;
            m2_reg <= mul1_reg ? m1_reg + (MAN_BITS + 2)'(prod) : m1_reg;
            d2_reg <= d1_reg;
            dir2_reg <= dir1_reg;
            r3_reg <= r3_next;
        end
    end

    // Renormalize: a carry past the hidden one shifts right and bumps the
    // exponent. The exponent is signed (two guard bits) for product underflow.
    always_comb
    begin
        msum = m2_reg;
        efin = e2_reg;
        if (msum[MAN_BITS+1:MAN_BITS] != 2'b00)
        begin
            efin = e2_reg + 1'b1;
            msum = (msum >> 1) - ((MAN_BITS + 2)'(1) << (MAN_BITS - 1));
        end
        mfin = msum[MAN_BITS-1:0];
        if (dir2_reg)
            r3_next = d2_reg;
        else if (efin[EXP_BITS+1])
            r3_next = '0;
        else if (efin[EXP_BITS:0] >= (EXP_BITS + 1)'(EXP_MAX))
            r3_next = 64'({EXP_MAX, {MAN_BITS{1'b0}}});
        else
            r3_next = 64'({efin[EXP_BITS-1:0], mfin});
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("held result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !dir2_reg && adv |=> r3_reg[63:W] == '0)
        else $error("minifloat result has upper bits set");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && in_valid |=> v1_reg)
        else $error("accepted item not captured");
endmodule
`default_nettype wire

// File: tb/unsigned_minifloat_add_mul_convert_checker.sv
// Checker that predicts the minifloat unit's results and compares them with the output channel.
module unsigned_minifloat_add_mul_convert_checker import umf_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MAN_BITS = MAN_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] result,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = EXP_BITS + MAN_BITS;
    localparam logic [63:0] MAN_MASK = (64'd1 << MAN_BITS) - 64'd1;
    localparam logic [63:0] EXP_MAX = (64'd1 << EXP_BITS) - 64'd1;
    localparam logic [63:0] WORD_MASK = (64'd1 << WIDTH) - 64'd1;
    localparam logic [63:0] MF_INF = EXP_MAX << MAN_BITS;
    localparam longint BIAS = (64'sd1 <<< (EXP_BITS - 1)) - 1;

    logic [63:0] expected_results[$];

    assign pending_count = expected_results.size();

    function automatic logic [63:0] pack_result(longint e, logic [63:0] m);
        longint ex;
        logic [63:0] mm;
        ex = e;
        mm = m;
        if (mm > MAN_MASK)
        begin
            ex++;
            mm = (mm >> 1) - (64'd1 << (MAN_BITS - 1));
        end
        if (ex < 0)
            return 64'd0;
        if (ex >= longint'(EXP_MAX))
            return MF_INF;
        return (64'(ex) << MAN_BITS) + mm;
    endfunction

    function automatic logic [63:0] minifloat_sum(logic [63:0] x, logic [63:0] y);
        logic [63:0] eb, es, mb, ms, d, total;
        if (x == 0)
            return y;
        if (y == 0)
            return x;
        if ((x >> MAN_BITS) >= (y >> MAN_BITS))
        begin
            eb = x >> MAN_BITS; mb = x & MAN_MASK; es = y >> MAN_BITS; ms = y & MAN_MASK;
        end
        else
        begin
            eb = y >> MAN_BITS; mb = y & MAN_MASK; es = x >> MAN_BITS; ms = x & MAN_MASK;
        end
        d = eb - es;
        total = mb;
        if (d <= MAN_BITS)
            total += (64'd1 << (MAN_BITS - d)) + (ms >> d);
        return pack_result(longint'(eb), total);
    endfunction

    function automatic logic [63:0] minifloat_product(logic [63:0] x, logic [63:0] y);
        logic [127:0] wide;
        logic [63:0] mx, my;
        longint e;
        if (x == 0 || y == 0)
            return 64'd0;
        mx = x & MAN_MASK;
        my = y & MAN_MASK;
        wide = {64'd0, mx} * {64'd0, my};
        e = longint'(x >> MAN_BITS) + longint'(y >> MAN_BITS) - BIAS;
        return pack_result(e, mx + my + 64'(wide >> MAN_BITS));
    endfunction

    function automatic logic [63:0] from_binary64(logic [63:0] bits);
        logic [63:0] mag;
        longint e;
        mag = bits & 64'h7fffffffffffffff;
        if (mag == 0)
            return 64'd0;
        e = longint'((mag >> D_MAN) & 64'h7ff) - D_BIAS + BIAS;
        if (e > 2 * BIAS)
            return MF_INF;
        if (e < 0)
            return 64'd0;
        return (64'(e) << MAN_BITS) | ((mag >> (D_MAN - MAN_BITS)) & MAN_MASK);
    endfunction

    function automatic logic [63:0] to_binary64(logic [63:0] x);
        logic [63:0] e;
        if (x == 0)
            return 64'd0;
        if (x == MF_INF)
            return D_INF;
        e = (x >> MAN_BITS) + 64'(D_BIAS - BIAS);
        return ((e & 64'h7ff) << D_MAN) | ((x & MAN_MASK) << (D_MAN - MAN_BITS));
    endfunction

    function automatic logic [63:0] predict_result(func_t f, logic [63:0] a, logic [63:0] b);
        case (f)
            FN_ADD: return minifloat_sum(a & WORD_MASK, b & WORD_MASK);
            FN_MUL: return minifloat_product(a & WORD_MASK, b & WORD_MASK);
            FN_FROM_D: return from_binary64(a);
            default: return to_binary64(a & WORD_MASK);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", result, 64'd0);
                else if (result !== expected_results[0])
                    report_mismatch("result", result, expected_results.pop_front());
                else
                    void'(expected_results.pop_front());
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_result(func_t'(func), operand_a, operand_b));
        end
    end
endmodule

// File: tb/unsigned_minifloat_add_mul_convert_top_tb.sv
// Testbench top: drives stimulus into the minifloat unit and reports the verdict.
module unsigned_minifloat_add_mul_convert_top_tb;
    import umf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_BITS = EXP_BITS_DEF;
    localparam int MAN_BITS = MAN_BITS_DEF;
    localparam int WIDTH = EXP_BITS + MAN_BITS;
    localparam int RANDOM_ITEMS = 1900;
    // Cycles without any transfer before the run is declared hung. This is far
    // longer than the longest receiver hold-off below, so it leaves a wide margin.
    localparam int IDLE_LIMIT = 5000;
    localparam logic [63:0] INF_PATTERN = ((64'd1 << EXP_BITS) - 64'd1) << MAN_BITS;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;

    unsigned_minifloat_add_mul_convert_top #(.EXP_BITS(EXP_BITS), .MAN_BITS(MAN_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
        .out_stall(out_stall), .result(result)
    );

    unsigned_minifloat_add_mul_convert_checker #(.EXP_BITS(EXP_BITS), .MAN_BITS(MAN_BITS))
        i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
        .out_stall(out_stall), .result(result), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Gap lengths: mostly zero or short, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A random minifloat that favors zero, INF, all-ones exponents and edge mantissas.
    // Upper garbage bits above the word width show up now and then.
    function automatic logic [63:0] random_minifloat();
        logic [63:0] e, m, v;
        int pick;
        pick = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0: e = 64'd0;
            1: e = (64'd1 << EXP_BITS) - 64'd1;
            2: e = (64'd1 << (EXP_BITS - 1)) - 64'd1 + $urandom_range(0, 3);
            default: e = $urandom_range(0, (1 << EXP_BITS) - 1);
        endcase
        case ($urandom_range(0, 4))
            0: m = 64'd0;
            1: m = (64'd1 << MAN_BITS) - 64'd1;
            default: m = {$urandom, $urandom} & ((64'd1 << MAN_BITS) - 64'd1);
        endcase
        v = (e << MAN_BITS) | m;
        if (pick == 0)
            v = 64'd0;
        else if (pick == 1)
            v = INF_PATTERN;
        if ($urandom_range(0, 7) == 0)
            v |= {$urandom, $urandom} << WIDTH;
        return v;
    endfunction

    // A random binary64 pattern whose exponent is often zero, all ones or near the minifloat range edges.
    function automatic logic [63:0] random_binary64();
        logic [63:0] e;
        case ($urandom_range(0, 4))
            0: e = 64'h7ff;
            1: e = 64'd0;
            2: e = 64'(D_BIAS) + $urandom_range(0, 1 << EXP_BITS) - (1 << (EXP_BITS - 1));
            default: e = $urandom_range(0, 2047);
        endcase
        return ({$urandom, $urandom} & 64'h800fffffffffffff) | (e << D_MAN);
    endfunction

    task automatic send_item(func_t f, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Receiver: random stalls, one early long hold-off so the pipeline fills up.
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        repeat (30) @(posedge clk);
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 300)
        begin
            @(posedge clk);
            hold++;
        end
        forever
        begin
            if ($urandom_range(0, 60) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 3) == 0);
                @(posedge clk);
            end
        end
    end

    // The watchdog counts cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("unsigned_minifloat_add_mul_convert_top test failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] one_val;
        logic [63:0] max_val;
        func_t f;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_ADD;
        operand_a = 64'd0;
        operand_b = 64'd0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        one_val = ((64'd1 << (EXP_BITS - 1)) - 64'd1) << MAN_BITS;
        max_val = INF_PATTERN - 64'd1;
        // Directed: zero operands, INF, largest finite values, wide alignment
        // shifts, product underflow and overflow, and conversions at the edges.
        send_item(FN_ADD, 64'd0, one_val);
        send_item(FN_ADD, max_val, 64'd0);
        send_item(FN_ADD, one_val, one_val);
        send_item(FN_ADD, max_val, max_val);
        send_item(FN_ADD, INF_PATTERN, one_val);
        send_item(FN_ADD, one_val, 64'd1);
        send_item(FN_ADD, one_val | (64'd1 << MAN_BITS), 64'hffffffff_ffffffff);
        send_item(FN_MUL, 64'd0, max_val);
        send_item(FN_MUL, one_val, 64'd0);
        send_item(FN_MUL, one_val, one_val);
        send_item(FN_MUL, max_val, max_val);
        send_item(FN_MUL, 64'd1, 64'd1);
        send_item(FN_MUL, INF_PATTERN, one_val);
        send_item(FN_MUL, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff);
        send_item(FN_FROM_D, 64'd0, 64'd0);
        send_item(FN_FROM_D, 64'h8000000000000000, 64'd0);
        send_item(FN_FROM_D, 64'h3ff0000000000000, 64'd0);
        send_item(FN_FROM_D, D_INF, 64'd0);
        send_item(FN_FROM_D, 64'hffffffffffffffff, 64'd0);
        send_item(FN_FROM_D, 64'h0000000000000001, 64'd0);
        send_item(FN_TO_D, 64'd0, 64'hffffffff_ffffffff);
        send_item(FN_TO_D, INF_PATTERN, 64'd0);
        send_item(FN_TO_D, INF_PATTERN | 64'd1, 64'd0);
        send_item(FN_TO_D, one_val, 64'd0);
        send_item(FN_TO_D, 64'hffffffff_ffffffff, 64'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            f = func_t'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0)
                send_item(f, {$urandom, $urandom}, {$urandom, $urandom});
            else if (f == FN_FROM_D)
                send_item(f, random_binary64(), {$urandom, $urandom});
            else
                send_item(f, random_minifloat(), random_minifloat());
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("unsigned_minifloat_add_mul_convert_top test passed");
        else
            $display("unsigned_minifloat_add_mul_convert_top test failed");
        $finish;
    end
endmodule
